### rtl/core/bpa_pkg.sv
// Shared constants, types and codes of the buddy page allocator.
`timescale 1ns / 1ps
package bpa_pkg;

    // Geometry
    localparam int NUM_PAGES = 32768;
    localparam int TOP_ORDER = 15;
    localparam int PAGE_W    = $clog2(NUM_PAGES);
    localparam int LINK_W    = $clog2(NUM_PAGES + 1);
    localparam int EXT_W     = LINK_W + 1;
    localparam int ORD_W     = $clog2(TOP_ORDER + 1);
    localparam int MARK_W    = $clog2(TOP_ORDER + 2);
    localparam int CFG_W     = 16;
    localparam int MODE_W    = 2;
    localparam int STATUS_W  = 3;

    typedef logic [PAGE_W-1:0] page_t;
    typedef logic [LINK_W-1:0] link_t;
    typedef logic [ORD_W-1:0]  ord_t;
    typedef logic [MARK_W-1:0] mark_t;

    // Mark of a page that does not start a free block
    localparam mark_t MARK_ALLOC = MARK_W'(TOP_ORDER + 1);
    // Link value meaning "no page"
    localparam link_t LINK_NULL  = LINK_W'(NUM_PAGES);

    typedef enum logic [MODE_W-1:0] {
        MODE_ALLOC = 2'd0,
        MODE_FREE  = 2'd1,
        MODE_INIT  = 2'd2,
        MODE_NOP   = 2'd3
    } mode_t;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK     = 3'd0,
        STATUS_EMPTY  = 3'd1,
        STATUS_ORDER  = 3'd2,
        STATUS_ALIGN  = 3'd3,
        STATUS_RANGE  = 3'd4,
        STATUS_DOUBLE = 3'd5
    } status_t;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_FREE_CHK,
        S_REL_RD,
        S_REL_CHK,
        S_UNL_RD,
        S_UNL_WR,
        S_PUSH_A,
        S_PUSH_B,
        S_SPLIT,
        S_INIT_NEXT,
        S_RESP
    } state_t;

endpackage

### rtl/core/bpa_req_if.sv
// Request channel of the buddy page allocator.
`timescale 1ns / 1ps
interface bpa_req_if;
    logic                         valid;
    logic                         ready;
    logic [bpa_pkg::MODE_W-1:0]   mode;
    logic [bpa_pkg::ORD_W-1:0]    order;
    logic [bpa_pkg::PAGE_W-1:0]   page_index;

    modport source (output valid, output mode, output order, output page_index, input ready);
    modport sink   (input valid, input mode, input order, input page_index, output ready);
endinterface

### rtl/core/bpa_rsp_if.sv
// Response channel of the buddy page allocator.
`timescale 1ns / 1ps
interface bpa_rsp_if;
    logic                         valid;
    logic                         ready;
    logic [bpa_pkg::PAGE_W-1:0]   page_out;
    logic [bpa_pkg::STATUS_W-1:0] status;

    modport source (output valid, output page_out, output status, input ready);
    modport sink   (input valid, input page_out, input status, output ready);
endinterface

### rtl/core/buddy_page_allocator.sv
// Buddy page allocator: sequencer around the page mark and link memories.
// Usage:
//   req carries one command per transfer (allocate, free, initialize); rsp returns
//   exactly one response (page_out, status) per command, in order.
//   cfg_we/cfg_wdata write first_usable_page; write it only while idle.
// Sequencing (one command at a time; req.ready is high only when idle):
//   allocate: unlink the smallest fitting block, then s splits (up to 15), each
//   pushing the upper half; free: a mark check, then m buddy merges (up to 15)
//   and a push. Order, alignment and range failures, an allocation with no
//   fitting block and the unused mode go straight to the response; a double
//   free answers after the mark check. initialize: a pass over the mark
//   memory, then each aligned block is released into the lists.
//   List steps read the mark and link memories through registered read ports
//   (each with a separate write port), followed by the write-back.
// Reset: the list heads go empty and a pass over all pages writes every page mark
//   to "allocated"; no command is taken during it (configuration writes are).
// Stall: the response waits in an output register; a finished command waits
//   for that register to drain, and a new command is taken as soon as the
//   block is back to idle, even while the last response is still held.
`timescale 1ns / 1ps
module buddy_page_allocator (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [bpa_pkg::CFG_W-1:0]   cfg_wdata,
    bpa_req_if.sink                     req,
    bpa_rsp_if.source                   rsp
);
    import bpa_pkg::*;

    // Control and working registers
    state_t               state_reg, state_next;
    mode_t                op_reg, op_next;
    page_t                pg_reg, pg_next;
    page_t                tgt_reg, tgt_next;
    ord_t                 ord_reg, ord_next;
    ord_t                 req_ord_reg, req_ord_next;
    ord_t                 tgt_ord_reg, tgt_ord_next;
    ord_t                 init_ord_reg, init_ord_next;
    link_t                h_reg, h_next;
    logic [EXT_W-1:0]     start_reg, start_next;
    page_t                clr_cnt_reg, clr_cnt_next;
    page_t                res_page_reg, res_page_next;
    status_t              res_status_reg, res_status_next;
    logic                 out_valid_reg, out_valid_next;
    page_t                out_page_reg, out_page_next;
    status_t              out_status_reg, out_status_next;
    link_t                head_reg [TOP_ORDER+1];
    link_t                head_next [TOP_ORDER+1];
    logic [CFG_W-1:0]     first_reg;

    // Memories
    mark_t                mark_mem [NUM_PAGES];
    link_t                next_mem [NUM_PAGES];
    link_t                prev_mem [NUM_PAGES];
    logic                 mark_we;
    page_t                mark_waddr, mark_raddr;
    mark_t                mark_wdata, mark_rd;
    logic                 next_we, prev_we;
    page_t                next_waddr, prev_waddr;
    link_t                next_wdata, prev_wdata, next_rd, prev_rd;

    // Decode
    mode_t                req_mode;
    link_t                rel_size, fr_size;
    page_t                mate;
    logic                 rel_top;
    logic                 fr_bad_order, fr_misalign, fr_range;
    logic                 al_found;
    ord_t                 al_ord;
    ord_t                 ini_ord;
    logic                 ini_done;
    logic                 p_valid, n_valid;
    logic                 split_more;
    ord_t                 split_ord;
    page_t                split_pg;
    link_t                push_head;

    assign req_mode     = mode_t'(req.mode);
    assign rel_size     = LINK_W'(1) << ord_reg;
    assign mate         = pg_reg ^ rel_size[PAGE_W-1:0];
    assign rel_top      = (32'(ord_reg) >= TOP_ORDER)
                       || (EXT_W'(mate) + EXT_W'(rel_size) > EXT_W'(NUM_PAGES));
    assign fr_size      = LINK_W'(1) << req.order;
    assign fr_bad_order = 32'(req.order) > TOP_ORDER;
    assign fr_misalign  = (req.page_index & (fr_size[PAGE_W-1:0] - PAGE_W'(1))) != '0;
    assign fr_range     = (EXT_W'(req.page_index) < EXT_W'(first_reg))
                       || (EXT_W'(req.page_index) + EXT_W'(fr_size) > EXT_W'(NUM_PAGES));
    assign ini_done     = start_reg >= EXT_W'(NUM_PAGES);
    assign p_valid      = prev_rd < LINK_NULL;
    assign n_valid      = next_rd < LINK_NULL;
    assign split_more   = ord_reg > req_ord_reg;
    assign split_ord    = ord_reg - ORD_W'(1);
    assign split_pg     = pg_reg + (PAGE_W'(1) << split_ord);
    assign push_head    = head_reg[tgt_ord_reg];

    // Smallest non-empty list at or above the requested order
    always_comb
    begin
        al_found = 1'b0;
        al_ord   = '0;
        for (int k = TOP_ORDER; k >= 0; k--)
        begin
            if (k >= int'(req.order) && head_reg[k] != LINK_NULL)
            begin
                al_found = 1'b1;
                al_ord   = ORD_W'(k);
            end
        end
    end

    // Largest aligned block that fits at the init cursor
    always_comb
    begin
        logic [EXT_W-1:0] sz;
        ini_ord = '0;
        for (int k = 1; k <= TOP_ORDER; k++)
        begin
            sz = EXT_W'(1) << k;
            if (((start_reg & (sz - EXT_W'(1))) == '0)
                && (start_reg + sz <= EXT_W'(NUM_PAGES)))
            begin
                ini_ord = ORD_W'(k);
            end
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_CLEAR:
            begin
                if (clr_cnt_reg == PAGE_W'(NUM_PAGES - 1))
                begin
                    state_next = (op_reg == MODE_INIT) ? S_INIT_NEXT : S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (req.valid)
                begin
                    case (req_mode)
                        MODE_ALLOC: state_next = (fr_bad_order || !al_found) ? S_RESP : S_UNL_RD;
                        MODE_FREE:  state_next = (fr_bad_order || fr_misalign || fr_range)
                                                 ? S_RESP : S_FREE_CHK;
                        MODE_INIT:  state_next = S_CLEAR;
                        default:    state_next = S_RESP;
                    endcase
                end
            end
            S_FREE_CHK:  state_next = (mark_rd != MARK_ALLOC) ? S_RESP : S_REL_RD;
            S_REL_RD:    state_next = rel_top ? S_PUSH_A : S_REL_CHK;
            S_REL_CHK:   state_next = (mark_rd == MARK_W'(ord_reg)) ? S_UNL_RD : S_PUSH_A;
            S_UNL_RD:    state_next = S_UNL_WR;
            S_UNL_WR:    state_next = (op_reg == MODE_ALLOC) ? S_SPLIT : S_REL_RD;
            S_PUSH_A:    state_next = S_PUSH_B;
            S_PUSH_B:
            begin
                case (op_reg)
                    MODE_ALLOC: state_next = S_SPLIT;
                    MODE_INIT:  state_next = S_INIT_NEXT;
                    default:    state_next = S_RESP;
                endcase
            end
            S_SPLIT:     state_next = split_more ? S_PUSH_A : S_RESP;
            S_INIT_NEXT: state_next = ini_done ? S_RESP : S_REL_RD;
            S_RESP:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:     state_next = S_IDLE;
        endcase
    end

    // Datapath and memory controls
    always_comb
    begin
        op_next         = op_reg;
        pg_next         = pg_reg;
        tgt_next        = tgt_reg;
        ord_next        = ord_reg;
        req_ord_next    = req_ord_reg;
        tgt_ord_next    = tgt_ord_reg;
        init_ord_next   = init_ord_reg;
        h_next          = h_reg;
        start_next      = start_reg;
        clr_cnt_next    = clr_cnt_reg;
        res_page_next   = res_page_reg;
        res_status_next = res_status_reg;
        out_valid_next  = out_valid_reg;
        out_page_next   = out_page_reg;
        out_status_next = out_status_reg;
        head_next       = head_reg;
        mark_we         = 1'b0;
        mark_waddr      = tgt_reg;
        mark_wdata      = MARK_ALLOC;
        next_we         = 1'b0;
        next_waddr      = tgt_reg;
        next_wdata      = LINK_NULL;
        prev_we         = 1'b0;
        prev_waddr      = tgt_reg;
        prev_wdata      = LINK_NULL;

        // mark read address
        case (state_reg)
            S_IDLE:   mark_raddr = req.page_index;
            S_REL_RD: mark_raddr = mate;
            default:  mark_raddr = pg_reg;
        endcase

        // response register drains on transfer
        if (out_valid_reg && rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_CLEAR:
            begin
                mark_we      = 1'b1;
                mark_waddr   = clr_cnt_reg;
                mark_wdata   = MARK_ALLOC;
                clr_cnt_next = clr_cnt_reg + PAGE_W'(1);
            end
            S_IDLE:
            begin
                if (req.valid)
                begin
                    op_next         = req_mode;
                    pg_next         = req.page_index;
                    ord_next        = req.order;
                    req_ord_next    = req.order;
                    res_page_next   = '0;
                    res_status_next = STATUS_OK;
                    case (req_mode)
                        MODE_ALLOC:
                        begin
                            if (fr_bad_order)
                            begin
                                res_status_next = STATUS_ORDER;
                            end
                            else if (!al_found)
                            begin
                                res_status_next = STATUS_EMPTY;
                            end
                            else
                            begin
                                tgt_next     = head_reg[al_ord][PAGE_W-1:0];
                                pg_next      = head_reg[al_ord][PAGE_W-1:0];
                                tgt_ord_next = al_ord;
                                ord_next     = al_ord;
                            end
                        end
                        MODE_FREE:
                        begin
                            if (fr_bad_order)
                            begin
                                res_status_next = STATUS_ORDER;
                            end
                            else if (fr_misalign)
                            begin
                                res_status_next = STATUS_ALIGN;
                            end
                            else if (fr_range)
                            begin
                                res_status_next = STATUS_RANGE;
                            end
                        end
                        MODE_INIT:
                        begin
                            for (int k = 0; k <= TOP_ORDER; k++)
                            begin
                                head_next[k] = LINK_NULL;
                            end
                            clr_cnt_next = '0;
                            start_next   = EXT_W'(first_reg);
                        end
                        default:
                        begin
                            res_status_next = STATUS_OK;
                        end
                    endcase
                end
            end
            S_FREE_CHK:
            begin
                if (mark_rd != MARK_ALLOC)
                begin
                    res_status_next = STATUS_DOUBLE;
                end
            end
            S_REL_RD:
            begin
                tgt_ord_next = ord_reg;
                tgt_next     = rel_top ? pg_reg : mate;
            end
            S_REL_CHK:
            begin
                if (mark_rd != MARK_W'(ord_reg))
                begin
                    tgt_next = pg_reg;
                end
            end
            S_UNL_WR:
            begin
                // splice the block out of its list
                next_we    = p_valid;
                next_waddr = prev_rd[PAGE_W-1:0];
                next_wdata = next_rd;
                prev_we    = n_valid;
                prev_waddr = next_rd[PAGE_W-1:0];
                prev_wdata = prev_rd;
                mark_we    = 1'b1;
                mark_waddr = tgt_reg;
                mark_wdata = MARK_ALLOC;
                if (!p_valid && head_reg[tgt_ord_reg] == LINK_W'(tgt_reg))
                begin
                    head_next[tgt_ord_reg] = next_rd;
                end
                // merge step: keep the lower buddy, one order up
                if (op_reg != MODE_ALLOC)
                begin
                    pg_next  = pg_reg & ~rel_size[PAGE_W-1:0];
                    ord_next = ord_reg + ORD_W'(1);
                end
            end
            S_PUSH_A:
            begin
                h_next     = push_head;
                prev_we    = 1'b1;
                prev_waddr = tgt_reg;
                prev_wdata = LINK_NULL;
                next_we    = 1'b1;
                next_waddr = tgt_reg;
                next_wdata = push_head;
                mark_we    = 1'b1;
                mark_waddr = tgt_reg;
                mark_wdata = MARK_W'(tgt_ord_reg);
                head_next[tgt_ord_reg] = LINK_W'(tgt_reg);
            end
            S_PUSH_B:
            begin
                if (h_reg < LINK_NULL)
                begin
                    prev_we    = 1'b1;
                    prev_waddr = h_reg[PAGE_W-1:0];
                    prev_wdata = LINK_W'(tgt_reg);
                end
                if (op_reg == MODE_INIT)
                begin
                    start_next = start_reg + (EXT_W'(1) << init_ord_reg);
                end
            end
            S_SPLIT:
            begin
                if (split_more)
                begin
                    ord_next     = split_ord;
                    tgt_next     = split_pg;
                    tgt_ord_next = split_ord;
                end
                else
                begin
                    res_page_next = pg_reg;
                end
            end
            S_INIT_NEXT:
            begin
                if (!ini_done)
                begin
                    pg_next       = start_reg[PAGE_W-1:0];
                    ord_next      = ini_ord;
                    init_ord_next = ini_ord;
                end
            end
            S_RESP:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next  = 1'b1;
                    out_page_next   = res_page_reg;
                    out_status_next = res_status_reg;
                end
            end
            default:
            begin
                op_next = op_reg;
            end
        endcase
    end

    // Handshake outputs
    assign req.ready    = (state_reg == S_IDLE);
    assign rsp.valid    = out_valid_reg;
    assign rsp.page_out = out_page_reg;
    assign rsp.status   = out_status_reg;

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            op_reg        <= MODE_NOP;
            clr_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
            first_reg     <= '0;
            for (int k = 0; k <= TOP_ORDER; k++)
            begin
                head_reg[k] <= LINK_NULL;
            end
        end
        else
        begin
            state_reg     <= state_next;
            op_reg        <= op_next;
            clr_cnt_reg   <= clr_cnt_next;
            out_valid_reg <= out_valid_next;
            head_reg      <= head_next;
            if (cfg_we)
            begin
                first_reg <= cfg_wdata;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        pg_reg         <= pg_next;
        tgt_reg        <= tgt_next;
        ord_reg        <= ord_next;
        req_ord_reg    <= req_ord_next;
        tgt_ord_reg    <= tgt_ord_next;
        init_ord_reg   <= init_ord_next;
        h_reg          <= h_next;
        start_reg      <= start_next;
        res_page_reg   <= res_page_next;
        res_status_reg <= res_status_next;
        out_page_reg   <= out_page_next;
        out_status_reg <= out_status_next;
    end

    // Page mark memory
    always_ff @(posedge clk)
    begin
        if (mark_we)
        begin
            mark_mem[mark_waddr] <= mark_wdata;
        end
        mark_rd <= mark_mem[mark_raddr];
    end

    // Forward link memory
    always_ff @(posedge clk)
    begin
        if (next_we)
        begin
            next_mem[next_waddr] <= next_wdata;
        end
        next_rd <= next_mem[tgt_reg];
    end

    // Backward link memory
    always_ff @(posedge clk)
    begin
        if (prev_we)
        begin
            prev_mem[prev_waddr] <= prev_wdata;
        end
        prev_rd <= prev_mem[tgt_reg];
    end

    // Checks
    a_rsp_from_resp: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_RESP))
        else $error("response raised outside the response state");

    a_split_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SPLIT) |-> (ord_reg >= req_ord_reg))
        else $error("split went below the requested order");

    a_resp_loads: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RESP && (!out_valid_reg || rsp.ready)) |=> out_valid_reg)
        else $error("finished command did not reach the output register");

    a_clear_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CLEAR && clr_cnt_reg == PAGE_W'(NUM_PAGES - 1))
        |=> (state_reg != S_CLEAR))
        else $error("mark clearing pass did not end");

endmodule

### tb/sv/testbench.sv
// Self-checking testbench of the buddy page allocator with its own list predictor.
`timescale 1ns / 1ps
module testbench;
    import bpa_pkg::*;

    localparam int IDLE_LIMIT = 200000;
    localparam int HOLD_CYCLES = 300;

    typedef struct {
        page_t   page;
        status_t status;
    } alloc_result_t;

    logic                clk;
    logic                rst_n;
    logic                cfg_we;
    logic [CFG_W-1:0]    cfg_wdata;

    bpa_req_if req_ch ();
    bpa_rsp_if rsp_ch ();

    buddy_page_allocator dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .req       (req_ch.sink),
        .rsp       (rsp_ch.source)
    );

    // Predictor state: page marks, list links, list heads, managed-range start
    logic [4:0] pm_mark [NUM_PAGES];
    int         pm_next [NUM_PAGES];
    int         pm_prev [NUM_PAGES];
    int         pm_head [TOP_ORDER+1];
    int         pm_first_page;

    alloc_result_t pending_results [$];
    int            held_page [$];
    int            held_order [$];

    int  mismatches;
    int  results_seen;
    int  idle_cycles;
    bit  hold_off_req;
    bit  calm;
    int  n_allocs, n_frees, n_inits;

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // List primitives
    function automatic void pm_push(int ord, int pg);
        int h;
        h = pm_head[ord];
        pm_prev[pg] = NUM_PAGES;
        pm_next[pg] = h;
        if (h < NUM_PAGES)
            pm_prev[h] = pg;
        pm_head[ord] = pg;
        pm_mark[pg] = ord[4:0];
    endfunction

    function automatic void pm_unlink(int ord, int pg);
        int p;
        int n;
        p = pm_prev[pg];
        n = pm_next[pg];
        if (p < NUM_PAGES)
            pm_next[p] = n;
        else if (pm_head[ord] == pg)
            pm_head[ord] = n;
        if (n < NUM_PAGES)
            pm_prev[n] = p;
        pm_next[pg] = NUM_PAGES;
        pm_prev[pg] = NUM_PAGES;
        pm_mark[pg] = MARK_ALLOC;
    endfunction

    // Merge with free buddies, then push the result
    function automatic void pm_release(int pg, int ord);
        int sz;
        int mate;
        while (ord < TOP_ORDER)
        begin
            sz = 1 << ord;
            mate = pg ^ sz;
            if (mate + sz > NUM_PAGES)
                break;
            if (pm_mark[mate] != ord[4:0])
                break;
            pm_unlink(ord, mate);
            if (mate < pg)
                pg = mate;
            ord++;
        end
        pm_push(ord, pg);
    endfunction

    function automatic void pm_clear();
        for (int i = 0; i <= TOP_ORDER; i++)
            pm_head[i] = NUM_PAGES;
        for (int i = 0; i < NUM_PAGES; i++)
            pm_mark[i] = MARK_ALLOC;
    endfunction

    // Expected response of one command; updates predictor state
    function automatic alloc_result_t predict_response(mode_t md, int ord, int pg);
        alloc_result_t r;
        int sz;
        int start;
        int o;
        int cur;
        r.page = '0;
        r.status = STATUS_OK;
        case (md)
            MODE_ALLOC:
            begin
                r.status = STATUS_EMPTY;
                for (cur = ord; cur <= TOP_ORDER; cur++)
                begin
                    if (pm_head[cur] < NUM_PAGES)
                    begin
                        start = pm_head[cur];
                        pm_unlink(cur, start);
                        while (cur > ord)
                        begin
                            cur--;
                            pm_push(cur, start + (1 << cur));
                        end
                        r.page = page_t'(start);
                        r.status = STATUS_OK;
                        break;
                    end
                end
            end
            MODE_FREE:
            begin
                sz = 1 << ord;
                if ((pg & (sz - 1)) != 0)
                    r.status = STATUS_ALIGN;
                else if (pg < pm_first_page || pg + sz > NUM_PAGES)
                    r.status = STATUS_RANGE;
                else if (pm_mark[pg] != MARK_ALLOC)
                    r.status = STATUS_DOUBLE;
                else
                    pm_release(pg, ord);
            end
            MODE_INIT:
            begin
                pm_clear();
                start = pm_first_page;
                while (start < NUM_PAGES)
                begin
                    o = TOP_ORDER;
                    while (o > 0)
                    begin
                        sz = 1 << o;
                        if ((start & (sz - 1)) == 0 && start + sz <= NUM_PAGES)
                            break;
                        o--;
                    end
                    pm_release(start, o);
                    start += 1 << o;
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        mismatches++;
        $display("mismatch %0s: got %0d expected %0d (response %0d)",
                 what, got, want, results_seen);
    endtask

    // Send one command; the predictor runs at the accepting edge
    task automatic send_cmd(mode_t md, int ord, int pg);
        int gap;
        alloc_result_t r;
        gap = calm ? 0 : $urandom_range(0, 13);
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid      <= 1'b1;
        req_ch.mode       <= md;
        req_ch.order      <= ord_t'(ord);
        req_ch.page_index <= page_t'(pg);
        do
            @(posedge clk);
        while (!(req_ch.valid && req_ch.ready));
        r = predict_response(md, ord, pg);
        pending_results.push_back(r);
        case (md)
            MODE_ALLOC: n_allocs++;
            MODE_FREE:  n_frees++;
            MODE_INIT:  n_inits++;
            default: ;
        endcase
        if (md == MODE_ALLOC && r.status == STATUS_OK)
        begin
            held_page.push_back(r.page);
            held_order.push_back(ord);
        end
        if (md == MODE_INIT)
        begin
            held_page.delete();
            held_order.delete();
        end
    endtask

    // Drain, then write first_usable_page while the block is idle
    task automatic set_first_page(int v);
        req_ch.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= CFG_W'(v);
        @(posedge clk);
        cfg_we <= 1'b0;
        pm_first_page = v;
    endtask

    // Free one block picked from those handed out
    task automatic free_held();
        int k;
        int pg;
        int ord;
        k = $urandom_range(0, held_page.size() - 1);
        pg = held_page[k];
        ord = held_order[k];
        held_page.delete(k);
        held_order.delete(k);
        send_cmd(MODE_FREE, ord, pg);
    endtask

    task automatic test_free_before_init();
        send_cmd(MODE_FREE, 0, 5);
        send_cmd(MODE_ALLOC, 0, 0);
        send_cmd(MODE_ALLOC, 0, 0);
        send_cmd(MODE_NOP, 7, 32767);
    endtask

    task automatic test_empty_range();
        set_first_page(32768);
        send_cmd(MODE_INIT, 0, 0);
        send_cmd(MODE_ALLOC, 15, 0);
        send_cmd(MODE_FREE, 0, 32767);
        set_first_page(32767);
        send_cmd(MODE_INIT, 0, 0);
        send_cmd(MODE_ALLOC, 0, 0);
        send_cmd(MODE_ALLOC, 0, 0);
        send_cmd(MODE_FREE, 0, 32767);
        send_cmd(MODE_FREE, 0, 32767);
    endtask

    task automatic test_split_merge_checks();
        set_first_page(0);
        send_cmd(MODE_INIT, 0, 0);
        send_cmd(MODE_ALLOC, 15, 0);
        send_cmd(MODE_FREE, 15, 0);
        send_cmd(MODE_ALLOC, 0, 0);
        send_cmd(MODE_ALLOC, 3, 0);
        send_cmd(MODE_FREE, 3, 1);
        send_cmd(MODE_FREE, 14, 16384);
        // interior page of a larger free block goes unnoticed
        send_cmd(MODE_FREE, 0, 20000);
        send_cmd(MODE_FREE, 15, 16384);
        while (held_page.size() != 0)
            free_held();
        set_first_page(100);
        send_cmd(MODE_FREE, 2, 64);
        send_cmd(MODE_FREE, 2, 100);
    endtask

    // Random phase: mostly alloc/free pairs on live blocks, some noise
    task automatic test_random(int n_items, int first_page);
        int r;
        int ord;
        set_first_page(first_page);
        send_cmd(MODE_INIT, 0, 0);
        for (int i = 0; i < n_items; i++)
        begin
            if (i % 60 == 0)
                calm = ($urandom_range(0, 3) == 0);
            r = $urandom_range(0, 99);
            if (r < 45 || (r < 85 && held_page.size() == 0))
            begin
                r = $urandom_range(0, 99);
                ord = (r < 70) ? $urandom_range(0, 3) :
                      (r < 95) ? $urandom_range(4, 8) : $urandom_range(9, 15);
                send_cmd(MODE_ALLOC, ord, 0);
            end
            else if (r < 85)
                free_held();
            else if (r < 96)
                send_cmd(MODE_FREE, $urandom_range(0, 15), $urandom_range(0, 32767));
            else
                send_cmd(mode_t'($urandom_range(0, 3)), $urandom_range(0, 15),
                         $urandom_range(0, 32767));
        end
        calm = 1'b0;
    endtask

    // Receiver holds off while commands keep coming back to back
    task automatic test_backpressure();
        calm = 1'b1;
        hold_off_req = 1'b1;
        for (int i = 0; i < 20; i++)
        begin
            if (i % 2 == 0 || held_page.size() == 0)
                send_cmd(MODE_ALLOC, $urandom_range(0, 2), 0);
            else
                free_held();
        end
        calm = 1'b0;
    endtask

    // Response ready with random stalls and one long hold-off on request
    initial
    begin
        int n;
        rsp_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            n = hold_off_req ? HOLD_CYCLES : (calm ? 0 : $urandom_range(0, 13));
            hold_off_req = 1'b0;
            if (n > 0)
            begin
                rsp_ch.ready <= 1'b0;
                repeat (n) @(posedge clk);
            end
            rsp_ch.ready <= 1'b1;
            do
                @(posedge clk);
            while (!(rsp_ch.valid && rsp_ch.ready));
        end
    end

    // Response check against the oldest expectation
    always @(posedge clk)
    begin
        alloc_result_t want;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            results_seen++;
            if (pending_results.size() == 0)
                report_mismatch("unexpected transfer", 1, 0);
            else
            begin
                want = pending_results.pop_front();
                if (rsp_ch.page_out !== want.page)
                    report_mismatch("page_out", rsp_ch.page_out, want.page);
                if (rsp_ch.status !== want.status)
                    report_mismatch("status", rsp_ch.status, want.status);
            end
        end
    end

    // Watchdog on cycles without any transfer
    always @(posedge clk)
    begin
        if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) || cfg_we)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("watchdog: no transfer for %0d cycles", IDLE_LIMIT);
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Main sequence
    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        req_ch.valid = 1'b0;
        req_ch.mode = MODE_NOP;
        req_ch.order = '0;
        req_ch.page_index = '0;
        mismatches = 0;
        results_seen = 0;
        idle_cycles = 0;
        hold_off_req = 1'b0;
        calm = 1'b0;
        n_allocs = 0;
        n_frees = 0;
        n_inits = 0;
        pm_first_page = 0;
        pm_clear();
        for (int i = 0; i < NUM_PAGES; i++)
        begin
            pm_next[i] = 0;
            pm_prev[i] = 0;
        end
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_free_before_init();
        test_empty_range();
        test_split_merge_checks();
        test_random(300, 0);
        test_backpressure();
        test_random(300, $urandom_range(1, 32766));
        test_random(250, $urandom_range(0, 40));
        test_random(250, 32768 - $urandom_range(1, 64));

        req_ch.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        $display("covered %0d allocations, %0d frees, %0d initializations",
                 n_allocs, n_frees, n_inits);
        $display("%0d responses checked, %0d mismatches", results_seen, mismatches);
        if (mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

### filelist.f
rtl/core/bpa_pkg.sv
rtl/core/bpa_req_if.sv
rtl/core/bpa_rsp_if.sv
rtl/core/buddy_page_allocator.sv
tb/sv/testbench.sv
